/* rtl/htr_pkg.sv */
// ----------------------------------------------------------------------------
// htr_pkg
// Shared types and constants for the tree header rebuild block.
// ----------------------------------------------------------------------------
package htr_pkg;

  // Number of stack cells in the chain.
  localparam int STACK_DEPTH = 128;
  // The stack pointer must be able to hold STACK_DEPTH itself.
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = 9;
  localparam int ADDR_W      = 8;
  localparam int SYM_W       = 7;
  localparam int VAL_W       = 9;

  localparam logic [IDX_W-1:0] FIRST_INTERNAL = IDX_W'(128);
  localparam logic [SP_W-1:0]  SP_FULL        = SP_W'(STACK_DEPTH);
  localparam logic signed [VAL_W-1:0] ROOT_VALUE = -9'sd1;

  // Stack cell operations.
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_PUSH = 2'd2;
  localparam logic [1:0] OP_POP  = 2'd3;

  // One stack entry: parent index and the flag that its left child is
  // still to come.
  typedef struct packed {
    logic [ADDR_W-1:0] parent;
    logic              left_pending;
  } entry_t;

  // Control that the top level hands to every cell.
  typedef struct packed {
    logic [1:0] op;
    entry_t     top_data;
  } cell_ctrl_t;

endpackage

/* rtl/huffman_tree_header_rebuild_top.sv */
// ----------------------------------------------------------------------------
// huffman_tree_header_rebuild_top
// Rebuilds a Huffman tree from a pre-order header, one node bit per word.
// ----------------------------------------------------------------------------
// Results appear in the cycle after their input word is accepted. Throughput:
// one input word per cycle while no result is stalled; the stack chain moves
// by one place per word and the output register frees itself when taken.
// Reset: synchronous, active high; it clears the index counter, the stack
// pointer, the finished flag and the output valid. Stack cell contents are not
// reset: only cells below the stack pointer are ever read.
module huffman_tree_header_rebuild_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           start_tree,
  input  logic                           node_bit,
  input  logic [htr_pkg::SYM_W-1:0]      leaf_symbol,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [htr_pkg::ADDR_W-1:0]     write_address,
  output logic signed [htr_pkg::VAL_W-1:0] write_value,
  output logic                           tree_complete,
  output logic                           overflow
);
  import htr_pkg::*;

  // Architectural state. The stack itself lives in the chain of cells, with
  // cell 0 holding the top of stack.
  logic [IDX_W-1:0] next_index;
  logic [SP_W-1:0]  sp;
  logic             finished;

  logic [IDX_W-1:0] next_index_next;
  logic [SP_W-1:0]  sp_next;
  logic             finished_next;

  entry_t     cell_q   [STACK_DEPTH];
  cell_ctrl_t ctrl;

  logic accept;

  // Values after an optional start of a new tree.
  logic [IDX_W-1:0] eff_index;
  logic [SP_W-1:0]  eff_sp;
  logic             eff_finished;

  logic             stack_empty;
  logic             popped;
  logic             clear_flag;
  logic [SP_W-1:0]  sp_after;
  logic signed [VAL_W-1:0] node_value;

  logic [ADDR_W-1:0]       res_address;
  logic signed [VAL_W-1:0] res_value;
  logic                    res_complete;
  logic                    res_overflow;

  // The output register frees itself in the cycle it is taken, so a new word
  // is taken while the old result is being delivered.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    eff_index    = start_tree ? FIRST_INTERNAL : next_index;
    eff_sp       = start_tree ? '0 : sp;
    eff_finished = start_tree ? 1'b0 : finished;

    stack_empty = (eff_sp == '0);
    clear_flag  = ~stack_empty & cell_q[0].left_pending;
    popped      = ~stack_empty & ~cell_q[0].left_pending;
    sp_after    = popped ? eff_sp - SP_W'(1) : eff_sp;

    // The root gets -1, a left child the negated parent, a right child the
    // parent itself.
    if (stack_empty) begin
      node_value = ROOT_VALUE;
    end else if (cell_q[0].left_pending) begin
      node_value = -$signed({1'b0, cell_q[0].parent});
    end else begin
      node_value = $signed({1'b0, cell_q[0].parent});
    end

    next_index_next = eff_index;
    sp_next         = eff_sp;
    finished_next   = eff_finished;
    ctrl.op         = OP_HOLD;
    ctrl.top_data   = '{parent: eff_index[ADDR_W-1:0], left_pending: 1'b1};
    res_address     = '0;
    res_value       = '0;
    res_complete    = 1'b0;
    res_overflow    = 1'b0;

    if (eff_finished) begin
      // A node after the tree is complete is refused.
      res_overflow = 1'b1;
    end else if (!node_bit) begin
      // Internal node: it becomes the new top of stack, waiting for its
      // left child. It is refused when indices or stack space run out.
      if (eff_index[IDX_W-1] || (sp_after >= SP_FULL)) begin
        res_overflow = 1'b1;
      end else begin
        // A consumed right-child slot is simply replaced in place.
        ctrl.op         = popped ? OP_LOAD : OP_PUSH;
        sp_next         = sp_after + SP_W'(1);
        next_index_next = eff_index + IDX_W'(1);
        res_address     = eff_index[ADDR_W-1:0];
        res_value       = node_value;
      end
    end else begin
      // Leaf: it fills the pending slot of the top entry.
      if (clear_flag) begin
        ctrl.op       = OP_LOAD;
        ctrl.top_data = '{parent: cell_q[0].parent, left_pending: 1'b0};
      end else if (popped) begin
        ctrl.op = OP_POP;
      end
      sp_next     = sp_after;
      res_address = {1'b0, leaf_symbol};
      res_value   = node_value;
      if (sp_after == '0) begin
        finished_next = 1'b1;
        res_complete  = 1'b1;
      end
    end

    if (!accept) begin
      ctrl.op = OP_HOLD;
    end
  end

  // Chain of stack cells. An entry that moves down below the top always has
  // its left child placed, so its pending flag is cleared on the way.
  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [1:0] cell_op;
      entry_t     up_in;
      entry_t     down_in;

      if (gi == 0) begin : g_top
        assign cell_op = ctrl.op;
        assign up_in   = ctrl.top_data;
      end else begin : g_body
        // Only the top cell is ever loaded directly.
        assign cell_op = (ctrl.op == OP_LOAD) ? OP_HOLD : ctrl.op;
        assign up_in   = '{parent: cell_q[gi-1].parent, left_pending: 1'b0};
      end

      if (gi == STACK_DEPTH - 1) begin : g_last
        assign down_in = cell_q[gi];
      end else begin : g_inner
        assign down_in = cell_q[gi+1];
      end

      htr_cell u_cell (
        .clk     (clk),
        .op      (cell_op),
        .up_in   (up_in),
        .down_in (down_in),
        .q       (cell_q[gi])
      );
    end
  endgenerate

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_index <= FIRST_INTERNAL;
      sp         <= '0;
      finished   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        next_index <= next_index_next;
        sp         <= sp_next;
        finished   <= finished_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      write_address <= res_address;
      write_value   <= res_value;
      tree_complete <= res_complete;
      overflow      <= res_overflow;
    end
  end

endmodule

/* rtl/htr_cell.sv */
// ----------------------------------------------------------------------------
// htr_cell
// One stack cell: holds an entry, takes its upper neighbor's entry on a push or
// a load and its lower neighbor's entry on a pop.
// ----------------------------------------------------------------------------
module htr_cell (
  input  logic              clk,
  input  logic [1:0]        op,
  input  htr_pkg::entry_t   up_in,
  input  htr_pkg::entry_t   down_in,
  output htr_pkg::entry_t   q
);
  import htr_pkg::*;

  entry_t q_next;

  always_comb begin
    case (op)
      OP_HOLD: q_next = q;
      OP_LOAD: q_next = up_in;
      OP_PUSH: q_next = up_in;
      OP_POP:  q_next = down_in;
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

/* rtl/htr_checker.sv */
// ----------------------------------------------------------------------------
// htr_checker
// Port-level checks of the tree header rebuild block, bound to its top level.
// ----------------------------------------------------------------------------
module htr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           start_tree,
  input logic                           node_bit,
  input logic [htr_pkg::SYM_W-1:0]      leaf_symbol,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [htr_pkg::ADDR_W-1:0]     write_address,
  input logic signed [htr_pkg::VAL_W-1:0] write_value,
  input logic                           tree_complete,
  input logic                           overflow
);
  import htr_pkg::*;

  // A refused node carries no write and never completes a tree.
  a_refused_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (write_address == '0 && write_value == '0 &&
                                 !tree_complete))
    else $error("refused node carries write data");

  // A leaf that starts a new tree is the root and completes it at once.
  a_root_leaf: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && start_tree && node_bit) |=>
      (out_valid && !overflow && tree_complete && write_value == ROOT_VALUE &&
       write_address == {1'b0, $past(leaf_symbol)}))
    else $error("root leaf did not complete the tree");

  // An internal node that starts a new tree takes the first internal index.
  a_root_internal: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && start_tree && !node_bit) |=>
      (out_valid && !overflow && !tree_complete && write_value == ROOT_VALUE &&
       write_address == FIRST_INTERNAL[ADDR_W-1:0]))
    else $error("root internal node has wrong index");

  // A result that is held back stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(write_address) &&
                                  $stable(write_value) && $stable(overflow) &&
                                  $stable(tree_complete)))
    else $error("stalled result changed");

endmodule

bind huffman_tree_header_rebuild_top htr_checker u_htr_checker (.*);
